[sv/pfx_pkg.sv]
// shared types and constants of the postfix expression evaluator
// command word passed from the front to the back, error codes, character codes
package pfx_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	// queue depth must be a power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int DATA_W = 32;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = 6;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_UNDER = 3'd1,
		ERR_OVER = 3'd2,
		ERR_DIVZ = 3'd3,
		ERR_EMPTY = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		CMD_NOP,
		CMD_PUSH,
		CMD_ADD,
		CMD_SUB,
		CMD_MUL,
		CMD_DIV
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [3:0] digit;
		logic last;
	} cmd_t;

endpackage

[sv/postfix_expression_evaluator.sv]
// top level of the postfix expression evaluator
// front end, command queue and stack engine; depends on pfx_pkg and all pfx modules
//
// channel   dir  tdata                        tlast              tuser
// s_axis    in   [7:0] token_char             end_of_expression  -
// m_axis    out  [31:0] value, [34:32] error  -                  -
//
// a digit or an ignored character is handled in the idle state of the stack engine
// + - * pass through accept, two registered stack reads, execute, write back
// / also waits in S_DIV for the divider, which produces one quotient bit per cycle
// end of expression passes through S_FIN, S_FRD and S_EMIT, waiting while the result register is full
// reset is asynchronous active low and empties the queue, stack and error state
// the queue keeps accepting words while the engine works or the result waits, until its two entries are full
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [pfx_pkg::IN_TDATA_W-1:0] s_axis_tdata, // [7:0] token_char
	input  logic s_axis_tlast,                           // end_of_expression
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [pfx_pkg::OUT_TDATA_W-1:0] m_axis_tdata // [31:0] value, [34:32] error_code
);

	logic front_valid;
	logic front_ready;
	pfx_pkg::cmd_t front_cmd;
	logic queue_valid;
	logic queue_ready;
	pfx_pkg::cmd_t queue_cmd;

	pfx_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cmd_valid     (front_valid),
		.cmd_ready     (front_ready),
		.cmd           (front_cmd)
	);

	pfx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_data  (front_cmd),
		.rd_valid (queue_valid),
		.rd_ready (queue_ready),
		.rd_data  (queue_cmd)
	);

	pfx_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (queue_valid),
		.cmd_ready     (queue_ready),
		.cmd           (queue_cmd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

[sv/pfx_front.sv]
// front end: accepts input words and classifies each character into a command
// depends on pfx_pkg
module pfx_front (
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [pfx_pkg::IN_TDATA_W-1:0] s_axis_tdata, // [7:0] token_char
	input  logic s_axis_tlast,                           // end_of_expression
	output logic cmd_valid,
	input  logic cmd_ready,
	output pfx_pkg::cmd_t cmd
);

	always_comb begin
		cmd.digit = s_axis_tdata[3:0];
		cmd.last = s_axis_tlast;
		case (s_axis_tdata) inside
			[pfx_pkg::CH_ZERO:pfx_pkg::CH_NINE]: cmd.kind = pfx_pkg::CMD_PUSH;
			pfx_pkg::CH_PLUS: cmd.kind = pfx_pkg::CMD_ADD;
			pfx_pkg::CH_MINUS: cmd.kind = pfx_pkg::CMD_SUB;
			pfx_pkg::CH_STAR: cmd.kind = pfx_pkg::CMD_MUL;
			pfx_pkg::CH_SLASH: cmd.kind = pfx_pkg::CMD_DIV;
			default: cmd.kind = pfx_pkg::CMD_NOP;
		endcase
	end

	assign cmd_valid = s_axis_tvalid;
	assign s_axis_tready = cmd_ready;

endmodule

[sv/pfx_queue.sv]
// short command queue between the front end and the stack engine
// depends on pfx_pkg
module pfx_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  pfx_pkg::cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output pfx_pkg::cmd_t rd_data
);

	localparam int QAW = (pfx_pkg::QUEUE_DEPTH > 1) ? $clog2(pfx_pkg::QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(pfx_pkg::QUEUE_DEPTH + 1);

	pfx_pkg::cmd_t entry_q [pfx_pkg::QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = (count_q != QCW'(pfx_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data = entry_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

endmodule

[sv/pfx_div.sv]
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pfx_pkg
module pfx_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [pfx_pkg::DATA_W-1:0] dividend,
	input  logic [pfx_pkg::DATA_W-1:0] divisor,
	output logic done,
	output logic [pfx_pkg::DATA_W-1:0] quotient
);

	localparam int W = pfx_pkg::DATA_W;

	logic [pfx_pkg::DIV_CNT_W-1:0] cnt_q;
	logic run_q;
	logic fix_q;
	logic neg_q;
	logic done_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic [W-1:0] quotient_q;
	logic [W:0] shifted;
	logic [W:0] diff;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		diff = shifted - {1'b0, den_q};
		mag_a = dividend[W-1] ? (W'(0) - dividend) : dividend;
		mag_b = divisor[W-1] ? (W'(0) - divisor) : divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
			fix_q <= 1'b0;
			neg_q <= 1'b0;
			done_q <= 1'b0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			quotient_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q <= mag_a;
				den_q <= mag_b;
				rem_q <= '0;
				neg_q <= dividend[W-1] ^ divisor[W-1];
				cnt_q <= pfx_pkg::DIV_CNT_W'(pfx_pkg::DIV_STEPS);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b1};
				end else begin
					rem_q <= shifted[W-1:0];
					quo_q <= {quo_q[W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - pfx_pkg::DIV_CNT_W'(1);
				if (cnt_q == pfx_pkg::DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				quotient_q <= neg_q ? (W'(0) - quo_q) : quo_q;
				done_q <= 1'b1;
				fix_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign quotient = quotient_q;

endmodule

[sv/pfx_back.sv]
// stack engine: operand stack memory, operator sequencing and result register
// depends on pfx_pkg and pfx_div
module pfx_back #(
	parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  pfx_pkg::cmd_t cmd,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [pfx_pkg::OUT_TDATA_W-1:0] m_axis_tdata // [31:0] value, [34:32] error_code
);

	localparam int W = pfx_pkg::DATA_W;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RA,
		S_RB,
		S_EX,
		S_DIV,
		S_WB,
		S_FIN,
		S_FRD,
		S_EMIT
	} state_t;

	state_t state_q;
	pfx_pkg::cmd_t cmd_q;
	pfx_pkg::err_t err_q;
	pfx_pkg::err_t out_err_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] addr_q;
	logic [W-1:0] rd_data_q;
	logic [W-1:0] right_q;
	logic [W-1:0] res_q;
	logic [W-1:0] out_value_q;
	logic out_valid_q;
	logic [W-1:0] stack_mem [STACK_DEPTH];

	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [W-1:0] wr_data;
	logic push_ok;
	logic div_start;
	logic div_done;
	logic [W-1:0] div_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign push_ok = (cnt_q < CW'(STACK_DEPTH));

	always_comb begin
		wr_en = 1'b0;
		wr_addr = AW'(cnt_q);
		wr_data = {{(W-4){1'b0}}, cmd.digit};
		if (state_q == S_WB) begin
			wr_en = 1'b1;
			wr_addr = AW'(cnt_q - CW'(2));
			wr_data = res_q;
		end else if (state_q == S_IDLE && cmd_valid && cmd.kind == pfx_pkg::CMD_PUSH) begin
			wr_en = push_ok;
		end
	end

	assign div_start = (state_q == S_EX) && (cmd_q.kind == pfx_pkg::CMD_DIV) && (right_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= stack_mem[addr_q];
	end

	pfx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_data_q),
		.divisor  (right_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= '0;
			err_q <= pfx_pkg::ERR_NONE;
			out_err_q <= pfx_pkg::ERR_NONE;
			cnt_q <= '0;
			addr_q <= '0;
			right_q <= '0;
			res_q <= '0;
			out_value_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.kind)
							pfx_pkg::CMD_PUSH: begin
								state_q <= cmd.last ? S_FIN : S_IDLE;
								if (push_ok) begin
									cnt_q <= cnt_q + CW'(1);
								end else if (err_q == pfx_pkg::ERR_NONE) begin
									err_q <= pfx_pkg::ERR_OVER;
								end
							end
							pfx_pkg::CMD_ADD, pfx_pkg::CMD_SUB,
							pfx_pkg::CMD_MUL, pfx_pkg::CMD_DIV: begin
								if (cnt_q < CW'(2)) begin
									state_q <= cmd.last ? S_FIN : S_IDLE;
									if (err_q == pfx_pkg::ERR_NONE) begin
										err_q <= pfx_pkg::ERR_UNDER;
									end
								end else begin
									addr_q <= AW'(cnt_q - CW'(1));
									state_q <= S_RA;
								end
							end
							default: state_q <= cmd.last ? S_FIN : S_IDLE;
						endcase
					end
				end
				S_RA: begin
					addr_q <= AW'(cnt_q - CW'(2));
					state_q <= S_RB;
				end
				S_RB: begin
					right_q <= rd_data_q;
					state_q <= S_EX;
				end
				S_EX: begin
					case (cmd_q.kind)
						pfx_pkg::CMD_ADD: begin
							res_q <= rd_data_q + right_q;
							state_q <= S_WB;
						end
						pfx_pkg::CMD_SUB: begin
							res_q <= rd_data_q - right_q;
							state_q <= S_WB;
						end
						pfx_pkg::CMD_MUL: begin
							res_q <= rd_data_q * right_q;
							state_q <= S_WB;
						end
						pfx_pkg::CMD_DIV: begin
							if (right_q == '0) begin
								res_q <= '0;
								state_q <= S_WB;
								if (err_q == pfx_pkg::ERR_NONE) begin
									err_q <= pfx_pkg::ERR_DIVZ;
								end
							end else begin
								state_q <= S_DIV;
							end
						end
						default: begin
							res_q <= '0;
							state_q <= S_WB;
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						res_q <= div_q;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					cnt_q <= cnt_q - CW'(1);
					state_q <= cmd_q.last ? S_FIN : S_IDLE;
				end
				S_FIN: begin
					addr_q <= AW'(cnt_q - CW'(1));
					state_q <= S_FRD;
				end
				S_FRD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || m_axis_tready) begin
						if (cnt_q == '0) begin
							out_value_q <= '0;
							out_err_q <= (err_q == pfx_pkg::ERR_NONE) ? pfx_pkg::ERR_EMPTY : err_q;
						end else begin
							out_value_q <= rd_data_q;
							out_err_q <= err_q;
						end
						cnt_q <= '0;
						err_q <= pfx_pkg::ERR_NONE;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(pfx_pkg::OUT_TDATA_W-W-3){1'b0}}, out_err_q, out_value_q};

endmodule

[bench/tb_postfix_expression_evaluator.sv]
// testbench for postfix_expression_evaluator: directed table, then random expressions
// results are checked against table values or a behavioral stack predictor kept in this file
// depends on pfx_pkg and the evaluator rtl
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator;
	import pfx_pkg::*;

	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int RANDOM_WORDS = 2000;
	localparam int QUIET_WORDS = 250;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_ROWS = 38;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ALL1 = 8'hFF;

	typedef struct packed {
		logic [7:0] ch;
		logic last;
		logic typed;
		logic [31:0] val;
		err_t code;
	} word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic last;
		logic [5:0] reps;
		logic typed;
		logic [31:0] val;
		err_t code;
	} row_t;

	typedef struct packed {
		logic [31:0] val;
		err_t code;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0; // [7:0] token_char
	logic s_axis_tlast = 1'b0;                // end_of_expression
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;    // [31:0] value, [34:32] error_code

	word_t stimulus[$];
	result_t pending_results[$];
	row_t directed_rows [N_ROWS];

	logic [31:0] opstack [STACK_DEPTH];
	int stack_depth = 0;
	err_t sticky_code = ERR_NONE;

	int work_words = 0;
	int err_cnt = 0;
	int results_seen = 0;
	int code_seen [5] = '{0, 0, 0, 0, 0};
	int cycles = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	postfix_expression_evaluator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [7:0] digit_char(input int n);
		return CH_ZERO + 8'(n);
	endfunction

	function automatic bit is_token(input logic [7:0] ch);
		return (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_PLUS || ch == CH_MINUS ||
			ch == CH_STAR || ch == CH_SLASH;
	endfunction

	function automatic logic [7:0] ignored_char();
		logic [7:0] ch;
		ch = 8'($urandom_range(0, 255));
		return is_token(ch) ? CH_SPACE : ch;
	endfunction

	function automatic logic [7:0] random_op();
		case ($urandom_range(0, 3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	function automatic void note_error(input err_t e);
		if (sticky_code == ERR_NONE)
			sticky_code = e;
	endfunction

	// stack evaluator; returns 1 when the word closes an expression
	function automatic bit evaluate_char(input logic [7:0] ch, input logic last,
			output logic [31:0] val, output err_t code);
		logic [31:0] lhs, rhs, res, mag_l, mag_r, quo;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (stack_depth >= STACK_DEPTH) begin
				note_error(ERR_OVER);
			end else begin
				opstack[stack_depth] = 32'(ch - CH_ZERO);
				stack_depth++;
			end
		end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR || ch == CH_SLASH) begin
			if (stack_depth < 2) begin
				note_error(ERR_UNDER);
			end else begin
				rhs = opstack[stack_depth-1];
				lhs = opstack[stack_depth-2];
				stack_depth -= 2;
				if (ch == CH_PLUS) begin
					res = lhs + rhs;
				end else if (ch == CH_MINUS) begin
					res = lhs - rhs;
				end else if (ch == CH_STAR) begin
					res = lhs * rhs;
				end else if (rhs == 32'd0) begin
					note_error(ERR_DIVZ);
					res = 32'd0;
				end else begin
					// magnitudes, then sign: truncation toward zero
					mag_l = lhs[31] ? -lhs : lhs;
					mag_r = rhs[31] ? -rhs : rhs;
					quo = mag_l / mag_r;
					res = (lhs[31] ^ rhs[31]) ? -quo : quo;
				end
				opstack[stack_depth] = res;
				stack_depth++;
			end
		end
		val = 32'd0;
		code = ERR_NONE;
		if (!last)
			return 1'b0;
		if (stack_depth == 0) begin
			code = (sticky_code != ERR_NONE) ? sticky_code : ERR_EMPTY;
		end else begin
			val = opstack[stack_depth-1];
			code = sticky_code;
		end
		stack_depth = 0;
		sticky_code = ERR_NONE;
		return 1'b1;
	endfunction

	function automatic void add_word(input logic [7:0] ch, input logic last);
		stimulus.push_back('{ch: ch, last: last, typed: 1'b0, val: 32'd0, code: ERR_NONE});
		work_words++;
	endfunction

	// valid expression with random digits, operators and filler characters
	function automatic void add_wellformed();
		int operands, pushed, depth;
		pushed = 0;
		depth = 0;
		operands = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 16) : $urandom_range(1, 8);
		while (!(pushed == operands && depth == 1)) begin
			if ($urandom_range(0, 7) == 0)
				add_word(ignored_char(), 1'b0);
			if (depth >= 2 && (pushed == operands || $urandom_range(0, 1) == 1)) begin
				add_word(random_op(), 1'b0);
				depth--;
			end else begin
				add_word(digit_char($urandom_range(0, 9)), 1'b0);
				pushed++;
				depth++;
			end
		end
		if ($urandom_range(0, 3) == 0)
			add_word(ignored_char(), 1'b1);
		else
			stimulus[stimulus.size()-1].last = 1'b1;
	endfunction

	function automatic void add_broken();
		int n;
		case ($urandom_range(0, 2))
			0: begin
				// runs past the top of the stack
				n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
				repeat (n) add_word(digit_char($urandom_range(0, 9)), 1'b0);
				repeat ($urandom_range(0, 3)) add_word(random_op(), 1'b0);
			end
			1: begin
				// too few operands
				repeat ($urandom_range(0, 1)) add_word(digit_char($urandom_range(0, 9)), 1'b0);
				repeat ($urandom_range(1, 3)) add_word(random_op(), 1'b0);
				repeat ($urandom_range(0, 1)) add_word(digit_char($urandom_range(0, 9)), 1'b0);
			end
			default: begin
				repeat ($urandom_range(0, 7))
					add_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				add_word(8'($urandom_range(0, 255)), 1'b0);
			end
		endcase
		stimulus[stimulus.size()-1].last = 1'b1;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin : check_result
		result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected word, expected none, actual value %0d error %0d",
					$time, $signed(m_axis_tdata[31:0]), m_axis_tdata[34:32]);
			end else begin
				want = pending_results.pop_front();
				results_seen++;
				code_seen[want.code]++;
				if (m_axis_tdata[31:0] !== want.val) begin
					err_cnt++;
					$display("%0t: value mismatch, expected %0d, actual %0d", $time,
						$signed(want.val), $signed(m_axis_tdata[31:0]));
				end
				if (m_axis_tdata[34:32] !== want.code) begin
					err_cnt++;
					$display("%0t: error code mismatch, expected %0d, actual %0d", $time,
						want.code, m_axis_tdata[34:32]);
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	initial begin
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	initial begin
		int i, k, hold_at, pause_at, n_directed;
		logic [31:0] pv;
		err_t pc;
		word_t w;

		directed_rows = '{
			'{CH_NUL, 1'b1, 6'd1, 1'b1, 32'd0, ERR_EMPTY},
			'{CH_PLUS, 1'b1, 6'd1, 1'b1, 32'd0, ERR_UNDER},
			'{digit_char(7), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_MINUS, 1'b1, 6'd1, 1'b1, 32'd7, ERR_UNDER},
			'{digit_char(9), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(0), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_SLASH, 1'b1, 6'd1, 1'b1, 32'd0, ERR_DIVZ},
			// first error wins: underflow after divide by zero
			'{digit_char(5), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(0), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_SLASH, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_PLUS, 1'b1, 6'd1, 1'b1, 32'd0, ERR_DIVZ},
			'{digit_char(8), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(3), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_MINUS, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_SPACE, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(4), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_STAR, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_ALL1, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(6), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_SLASH, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(2), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_PLUS, 1'b1, 6'd1, 1'b0, 32'd0, ERR_NONE},
			// negative quotient
			'{digit_char(3), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(7), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_MINUS, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(3), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_SLASH, 1'b1, 6'd1, 1'b0, 32'd0, ERR_NONE},
			// stack full, further digits dropped
			'{digit_char(9), 1'b0, 6'd17, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(1), 1'b1, 6'd1, 1'b1, 32'd9, ERR_OVER},
			// 8^10 * 2 wraps to the most negative value, then divided by -1
			'{digit_char(8), 1'b0, 6'd10, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(2), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_STAR, 1'b0, 6'd10, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(0), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{digit_char(1), 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_MINUS, 1'b0, 6'd1, 1'b0, 32'd0, ERR_NONE},
			'{CH_SLASH, 1'b1, 6'd1, 1'b1, 32'h8000_0000, ERR_NONE},
			'{digit_char(9), 1'b1, 6'd1, 1'b1, 32'd9, ERR_NONE},
			'{CH_ALL1, 1'b1, 6'd1, 1'b1, 32'd0, ERR_EMPTY}
		};

		for (i = 0; i < N_ROWS; i++) begin
			for (k = 0; k < int'(directed_rows[i].reps); k++) begin
				w.ch = directed_rows[i].ch;
				w.last = (k == int'(directed_rows[i].reps) - 1) ? directed_rows[i].last : 1'b0;
				w.typed = w.last & directed_rows[i].typed;
				w.val = directed_rows[i].val;
				w.code = directed_rows[i].code;
				stimulus.push_back(w);
			end
		end
		n_directed = stimulus.size();
		work_words = 0;
		while (work_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 9) < 7)
				add_wellformed();
			else
				add_broken();
		end
		hold_at = n_directed + 600;
		pause_at = n_directed + 1200;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < stimulus.size(); i++) begin
			w = stimulus[i];
			quiet = (i >= stimulus.size() - QUIET_WORDS);
			if (i == hold_at)
				hold_req = 1'b1;
			if (!quiet && i >= n_directed && $urandom_range(0, 7) == 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			if (i == pause_at) begin
				s_axis_tvalid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			s_axis_tdata <= w.ch;
			s_axis_tlast <= w.last;
			s_axis_tvalid <= 1'b1;
			do @(posedge clk); while (!s_axis_tready);
			if (evaluate_char(w.ch, w.last, pv, pc)) begin
				if (w.typed)
					pending_results.push_back('{val: w.val, code: w.code});
				else
					pending_results.push_back('{val: pv, code: pc});
			end
		end
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d words in %0d cycles, %0d results checked", stimulus.size(), cycles,
			results_seen);
		$display("result codes: %0d ok, %0d underflow, %0d overflow, %0d div by zero, %0d empty",
			code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4]);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
sv/pfx_pkg.sv
sv/pfx_front.sv
sv/pfx_queue.sv
sv/pfx_div.sv
sv/pfx_back.sv
sv/postfix_expression_evaluator.sv
bench/tb_postfix_expression_evaluator.sv
